/* hw/rtl/fpsqrt_pkg.sv */
package fpsqrt_pkg;

  // default operand format: signed q16.16
  localparam int FRAC_BITS_DEF     = 16;
  localparam int OPERAND_WIDTH_DEF = 32;

  // result root port width and its saturation value
  localparam int                  ROOT_OUT_W = 24;
  localparam logic [ROOT_OUT_W-1:0] ROOT_MAX = {ROOT_OUT_W{1'b1}};

  // root bits resolved in each pipeline stage
  localparam int STEPS_PER_STAGE = 4;

  // control that travels with each beat through the pipe
  typedef struct packed {
    logic valid;
    logic neg;
  } fpsqrt_ctl_t;

endpackage

/* hw/rtl/fpsqrt_stage.sv */
module fpsqrt_stage #(
  parameter int RAD_W  = 48,
  parameter int ROOT_W = 24,
  parameter int REM_W  = 27
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fpsqrt_pkg::fpsqrt_ctl_t  ctl_i,
  input  logic [RAD_W-1:0]         rad_i,
  input  logic [REM_W-1:0]         rem_i,
  input  logic [ROOT_W-1:0]        root_i,
  output fpsqrt_pkg::fpsqrt_ctl_t  ctl_o,
  output logic [RAD_W-1:0]         rad_o,
  output logic [REM_W-1:0]         rem_o,
  output logic [ROOT_W-1:0]        root_o
);
  import fpsqrt_pkg::*;

  localparam int SHIFT_W = 2 * STEPS_PER_STAGE;

  fpsqrt_ctl_t       ctl_r;
  logic [RAD_W-1:0]  rad_r,  rad_nxt;
  logic [REM_W-1:0]  rem_r,  rem_nxt;
  logic [ROOT_W-1:0] root_r, root_nxt;

  // restoring digit steps, one radicand bit pair each, top pairs first
  always_comb begin
    logic [REM_W-1:0]  rem_v;
    logic [ROOT_W-1:0] root_v;
    logic [REM_W-1:0]  trial;
    rem_v  = rem_i;
    root_v = root_i;
    for (int j = 0; j < STEPS_PER_STAGE; j++) begin
      rem_v = {rem_v[REM_W-3:0], rad_i[RAD_W-1-2*j -: 2]};
      trial = {1'b0, root_v, 2'b01};
      if (rem_v >= trial) begin
        rem_v  = rem_v - trial;
        root_v = {root_v[ROOT_W-2:0], 1'b1};
      end else begin
        root_v = {root_v[ROOT_W-2:0], 1'b0};
      end
    end
    rem_nxt  = rem_v;
    root_nxt = root_v;
    rad_nxt  = {rad_i[RAD_W-SHIFT_W-1:0], {SHIFT_W{1'b0}}};
  end

  // stage control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_i;
    end
  end

  // stage payload registers
  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign ctl_o  = ctl_r;
  assign rad_o  = rad_r;
  assign rem_o  = rem_r;
  assign root_o = root_r;

endmodule

/* hw/rtl/fixed_point_square_root.sv */
// the operand passes through the root stages and then the output register,
// 6 root stages at the default sizes
// throughput: one operand per cycle; busy stays low, set by the fully pipelined root stages
// each root stage resolves four root bits with four chained compare-subtract steps
// reset: synchronous active-low rst_n clears all pipeline valid bits and out_strobe
// the receiver cannot stall: out_strobe marks each result for exactly one cycle
module fixed_point_square_root #(
  parameter int FRAC_BITS     = fpsqrt_pkg::FRAC_BITS_DEF,
  parameter int OPERAND_WIDTH = fpsqrt_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [OPERAND_WIDTH-1:0]     in_operand,
  output logic                                out_strobe,
  output logic [fpsqrt_pkg::ROOT_OUT_W-1:0]   out_root,
  output logic                                out_domain_error
);
  import fpsqrt_pkg::*;

  localparam int RAD_BITS  = OPERAND_WIDTH - 1 + FRAC_BITS;
  localparam int PAIRS     = (RAD_BITS + 1) / 2;
  localparam int NSTAGES   = (PAIRS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
  localparam int TOT_PAIRS = NSTAGES * STEPS_PER_STAGE;
  localparam int RAD_W     = 2 * TOT_PAIRS;
  localparam int ROOT_W    = TOT_PAIRS;
  localparam int REM_W     = ROOT_W + 3;
  localparam int CMP_W     = (ROOT_W > ROOT_OUT_W) ? ROOT_W : ROOT_OUT_W;
  localparam int LATENCY   = NSTAGES + 1;

  fpsqrt_ctl_t       ctl_s  [NSTAGES+1];
  logic [RAD_W-1:0]  rad_s  [NSTAGES+1];
  logic [REM_W-1:0]  rem_s  [NSTAGES+1];
  logic [ROOT_W-1:0] root_s [NSTAGES+1];

  logic                  out_strobe_r;
  logic [ROOT_OUT_W-1:0] out_root_r, out_root_nxt;
  logic                  out_domain_error_r;
  logic [CMP_W-1:0]      root_ext;

  // pipe never stalls, so an operand is taken every cycle
  assign busy = 1'b0;

  // radicand is the magnitude shifted up by the fraction bits; zeroed when negative
  always_comb begin
    ctl_s[0].valid = start && !busy;
    ctl_s[0].neg   = in_operand[OPERAND_WIDTH-1];
    rad_s[0]       = '0;
    if (!in_operand[OPERAND_WIDTH-1]) begin
      rad_s[0] = RAD_W'({in_operand[OPERAND_WIDTH-2:0], {FRAC_BITS{1'b0}}});
    end
    rem_s[0]  = '0;
    root_s[0] = '0;
  end

  // root stages
  for (genvar s = 0; s < NSTAGES; s++) begin : g_stage
    fpsqrt_stage #(
      .RAD_W  (RAD_W),
      .ROOT_W (ROOT_W),
      .REM_W  (REM_W)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctl_i  (ctl_s[s]),
      .rad_i  (rad_s[s]),
      .rem_i  (rem_s[s]),
      .root_i (root_s[s]),
      .ctl_o  (ctl_s[s+1]),
      .rad_o  (rad_s[s+1]),
      .rem_o  (rem_s[s+1]),
      .root_o (root_s[s+1])
    );
  end

  // saturate wide roots, force zero on domain error
  always_comb begin
    root_ext = CMP_W'(root_s[NSTAGES]);
    if (ctl_s[NSTAGES].neg) begin
      out_root_nxt = '0;
    end else if (root_ext > CMP_W'(ROOT_MAX)) begin
      out_root_nxt = ROOT_MAX;
    end else begin
      out_root_nxt = root_ext[ROOT_OUT_W-1:0];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl_s[NSTAGES].valid;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    out_root_r         <= out_root_nxt;
    out_domain_error_r <= ctl_s[NSTAGES].neg;
  end

  assign out_strobe       = out_strobe_r;
  assign out_root         = out_root_r;
  assign out_domain_error = out_domain_error_r;

endmodule

/* hw/rtl/fpsqrt_chk.sv */
module fpsqrt_chk #(
  parameter int OPERAND_WIDTH = fpsqrt_pkg::OPERAND_WIDTH_DEF,
  parameter int LATENCY       = 7
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic [OPERAND_WIDTH-1:0]           in_operand,
  input logic                               out_strobe,
  input logic [fpsqrt_pkg::ROOT_OUT_W-1:0]  out_root,
  input logic                               out_domain_error
);
  import fpsqrt_pkg::*;

  localparam int CNT_W = $clog2(LATENCY + 1);

  logic [CNT_W-1:0] run_r;
  logic             settled;

  // edges since reset release, saturating at the pipe latency
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else if (run_r != CNT_W'(LATENCY)) begin
      run_r <= run_r + 1'b1;
    end
  end

  assign settled = (run_r == CNT_W'(LATENCY));

  // one result beat per accepted beat, checked once the pipe has settled after reset
  a_strobe_latency: assert property (@(posedge clk) disable iff (!rst_n)
    settled |-> (out_strobe == $past(start && !busy, LATENCY)))
    else $error("result beat does not match accepted beat");

  // domain error flag follows the operand sign
  a_domain_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (settled && out_strobe) |-> (out_domain_error == $past(in_operand[OPERAND_WIDTH-1], LATENCY)))
    else $error("domain error flag does not follow operand sign");

  // a negative operand gives a zero root
  a_domain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_domain_error) |-> (out_root == '0))
    else $error("nonzero root on domain error");

  // no strobe comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !$past(rst_n) |-> !out_strobe)
    else $error("result beat right after reset");

endmodule

bind fixed_point_square_root fpsqrt_chk #(
  .OPERAND_WIDTH (OPERAND_WIDTH),
  .LATENCY       (LATENCY)
) u_fpsqrt_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_operand       (in_operand),
  .out_strobe       (out_strobe),
  .out_root         (out_root),
  .out_domain_error (out_domain_error)
);
